>>> src/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: shared constants for temperature and humidity compensation
// Register indexes, saturation limits and fixed-point offsets.
// ----------------------------------------------------------------------------
`default_nettype none

package htc_pkg;

    // Configuration register indexes
    typedef logic [2:0] reg_index_t;
    localparam reg_index_t REG_TEMP_ONE      = 3'd0;
    localparam reg_index_t REG_TEMP_TWO      = 3'd1;
    localparam reg_index_t REG_TEMP_THREE    = 3'd2;
    localparam reg_index_t REG_HUM_ONE       = 3'd3;
    localparam reg_index_t REG_HUM_TWO       = 3'd4;
    localparam reg_index_t REG_HUM_THREE     = 3'd5;
    localparam reg_index_t REG_HUM_FOUR_FIVE = 3'd6;
    localparam reg_index_t REG_HUM_SIX       = 3'd7;

    localparam int CFG_WIDTH = 24;

    // Saturation limits
    localparam logic signed [24:0] FINE_MIN  = -25'sd524288;
    localparam logic signed [24:0] FINE_MAX  = 25'sd524287;
    localparam logic signed [15:0] TEMP_MIN  = -16'sd4000;
    localparam logic signed [15:0] TEMP_MAX  = 16'sd8500;
    localparam logic signed [56:0] HUM_Q_MAX = 57'sd419430400;

    // Fixed-point offsets
    localparam logic signed [20:0] FINE_OFFSET  = 21'sd76800;
    localparam logic signed [23:0] TEMP_ROUND   = 24'sd128;
    localparam logic signed [35:0] U_ROUND      = 36'sd16384;
    localparam logic signed [20:0] P3_OFFSET    = 21'sd32768;
    localparam logic signed [31:0] V_OFFSET     = 32'sd2097152;
    localparam logic signed [47:0] V_ROUND      = 48'sd8192;

endpackage

`default_nettype wire

>>> src/humidity_temperature_compensation.sv
// ----------------------------------------------------------------------------
// humidity_temperature_compensation
// Pipelined fixed-point compensation of a raw temperature and humidity word.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write the eight calibration registers through wr_en,
//   wr_index and wr_data while no word is in flight; writes take effect at
//   once and there is no read-back. All registers reset to zero.
//   Input: a word (raw_temperature, raw_humidity) is taken at every rising
//   edge with start high and busy low. busy is always low, so a new word may
//   enter in every cycle.
//   Output: done pulses for one cycle with temperature_centi, humidity_frac
//   and fine_temperature; the receiver cannot hold it off.
//   Throughput: one word per cycle. Ten register stages, none with more
//   than one product in series, lie between the accepting edge and done.
//   Reset: rst_n clears the calibration registers and all stage valid bits;
//   words in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temperature_compensation
    import htc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [2:0]           wr_index,
    input  wire logic [CFG_WIDTH-1:0] wr_data,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [19:0]          raw_temperature,
    input  wire logic [15:0]          raw_humidity,
    output logic                      done,
    output logic signed [14:0]        temperature_centi,
    output logic [16:0]               humidity_frac,
    output logic signed [19:0]        fine_temperature
);

    localparam int STAGES = 10;

    // Calibration registers
    logic        [15:0] t1_reg;
    logic signed [15:0] t2_reg;
    logic signed [15:0] t3_reg;
    logic        [7:0]  h1_reg;
    logic signed [15:0] h2_reg;
    logic        [7:0]  h3_reg;
    logic        [23:0] h45_reg;
    logic signed [7:0]  h6_reg;

    logic signed [11:0] h4;
    logic signed [11:0] h5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            t3_reg  <= '0;
            h1_reg  <= '0;
            h2_reg  <= '0;
            h3_reg  <= '0;
            h45_reg <= '0;
            h6_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TEMP_ONE:      t1_reg  <= wr_data[15:0];
                REG_TEMP_TWO:      t2_reg  <= $signed(wr_data[15:0]);
                REG_TEMP_THREE:    t3_reg  <= $signed(wr_data[15:0]);
                REG_HUM_ONE:       h1_reg  <= wr_data[7:0];
                REG_HUM_TWO:       h2_reg  <= $signed(wr_data[15:0]);
                REG_HUM_THREE:     h3_reg  <= wr_data[7:0];
                REG_HUM_FOUR_FIVE: h45_reg <= wr_data[23:0];
                REG_HUM_SIX:       h6_reg  <= $signed(wr_data[7:0]);
                default:           t1_reg  <= t1_reg;
            endcase
        end
    end

    assign h4 = $signed(h45_reg[23:12]);
    assign h5 = $signed(h45_reg[11:0]);

    assign busy = 1'b0;

    // Valid bits travel alongside the data
    logic [STAGES-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[STAGES-2:0], start};
    end

    assign done = valid_reg[STAGES-1];

    // Stage 1: linear and square differences
    logic signed [17:0] s1_diff;
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_aprod_next, s1_aprod_reg;
    logic signed [33:0] s1_dd_next, s1_dd_reg;
    logic        [15:0] s1_rh_reg;

    assign s1_diff       = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1_reg, 1'b0});
    assign s1_d          = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1_reg});
    assign s1_aprod_next = s1_diff * t2_reg;
    assign s1_dd_next    = s1_d * s1_d;

    always_ff @(posedge clk)
    begin
        s1_aprod_reg <= s1_aprod_next;
        s1_dd_reg    <= s1_dd_next;
        s1_rh_reg    <= raw_humidity;
    end

    // Stage 2: square term gain
    logic signed [21:0] s2_ddsh;
    logic signed [37:0] s2_bprod_next, s2_bprod_reg;
    logic signed [22:0] s2_a_reg;
    logic        [15:0] s2_rh_reg;

    assign s2_ddsh       = $signed(s1_dd_reg[33:12]);
    assign s2_bprod_next = s2_ddsh * t3_reg;

    always_ff @(posedge clk)
    begin
        s2_bprod_reg <= s2_bprod_next;
        s2_a_reg     <= $signed(s1_aprod_reg[33:11]);
        s2_rh_reg    <= s1_rh_reg;
    end

    // Stage 3: fine temperature with saturation
    logic signed [24:0] s3_sum;
    logic signed [19:0] s3_fine_next, s3_fine_reg;
    logic        [15:0] s3_rh_reg;

    assign s3_sum = {{2{s2_a_reg[22]}}, s2_a_reg} + {s2_bprod_reg[37], s2_bprod_reg[37:14]};

    always_comb
    begin
        if (s3_sum < FINE_MIN)
            s3_fine_next = FINE_MIN[19:0];
        else if (s3_sum > FINE_MAX)
            s3_fine_next = FINE_MAX[19:0];
        else
            s3_fine_next = s3_sum[19:0];
    end

    always_ff @(posedge clk)
    begin
        s3_fine_reg <= s3_fine_next;
        s3_rh_reg   <= s2_rh_reg;
    end

    // Stage 4: temperature, humidity offset sum and temperature products
    logic signed [23:0] s4_f24;
    logic signed [23:0] s4_tsum;
    logic signed [15:0] s4_tq;
    logic signed [14:0] s4_temp_next;
    logic signed [20:0] s4_x;
    logic signed [35:0] s4_unum_next, s4_unum_reg;
    logic signed [29:0] s4_p6_next, s4_p6_reg;
    logic signed [29:0] s4_p3_next, s4_p3_reg;
    logic signed [35:0] s4_h5x;

    assign s4_f24  = {{4{s3_fine_reg[19]}}, s3_fine_reg};
    assign s4_tsum = (s4_f24 <<< 2) + s4_f24 + TEMP_ROUND;
    assign s4_tq   = $signed(s4_tsum[23:8]);

    always_comb
    begin
        if (s4_tq < TEMP_MIN)
            s4_temp_next = TEMP_MIN[14:0];
        else if (s4_tq > TEMP_MAX)
            s4_temp_next = TEMP_MAX[14:0];
        else
            s4_temp_next = s4_tq[14:0];
    end

    assign s4_x         = {s3_fine_reg[19], s3_fine_reg} - FINE_OFFSET;
    assign s4_h5x       = s4_x * h5;
    assign s4_unum_next = $signed({6'd0, s3_rh_reg, 14'd0})
                        - $signed({{4{h4[11]}}, h4, 20'd0})
                        - s4_h5x + U_ROUND;
    assign s4_p6_next   = s4_x * h6_reg;
    assign s4_p3_next   = s4_x * $signed({1'b0, h3_reg});

    // Hold temperature and fine value alongside the humidity path
    logic signed [14:0] temp_pipe_reg [4:STAGES];
    logic signed [19:0] fine_pipe_reg [4:STAGES];

    always_ff @(posedge clk)
    begin
        s4_unum_reg      <= s4_unum_next;
        s4_p6_reg        <= s4_p6_next;
        s4_p3_reg        <= s4_p3_next;
        temp_pipe_reg[4] <= s4_temp_next;
        fine_pipe_reg[4] <= s3_fine_reg;
        for (int i = 5; i <= STAGES; i++)
        begin
            temp_pipe_reg[i] <= temp_pipe_reg[i-1];
            fine_pipe_reg[i] <= fine_pipe_reg[i-1];
        end
    end

    // Stage 5: humidity offset and temperature product
    logic signed [19:0] s5_p6s;
    logic signed [20:0] s5_p3s;
    logic signed [40:0] s5_w_next, s5_w_reg;
    logic signed [20:0] s5_u_reg;

    assign s5_p6s    = $signed(s4_p6_reg[29:10]);
    assign s5_p3s    = {{2{s4_p3_reg[29]}}, s4_p3_reg[29:11]};
    assign s5_w_next = s5_p6s * (s5_p3s + P3_OFFSET);

    always_ff @(posedge clk)
    begin
        s5_w_reg <= s5_w_next;
        s5_u_reg <= $signed(s4_unum_reg[35:15]);
    end

    // Stage 6: humidity gain
    logic signed [31:0] s6_v1;
    logic signed [47:0] s6_vp_next, s6_vp_reg;
    logic signed [20:0] s6_u_reg;

    assign s6_v1      = {s5_w_reg[40], s5_w_reg[40:10]} + V_OFFSET;
    assign s6_vp_next = s6_v1 * h2_reg;

    always_ff @(posedge clk)
    begin
        s6_vp_reg <= s6_vp_next;
        s6_u_reg  <= s5_u_reg;
    end

    // Stage 7: uncorrected humidity
    logic signed [47:0] s7_vr;
    logic signed [26:0] s7_v;
    logic signed [47:0] s7_y_next, s7_y_reg;

    assign s7_vr     = s6_vp_reg + V_ROUND;
    assign s7_v      = $signed(s7_vr[40:14]);
    assign s7_y_next = s6_u_reg * s7_v;

    always_ff @(posedge clk)
    begin
        s7_y_reg <= s7_y_next;
    end

    // Stage 8: square of the scaled humidity
    logic signed [28:0] s8_q;
    logic signed [57:0] s8_qq_next, s8_qq_reg;
    logic signed [47:0] s8_y_reg;

    assign s8_q       = $signed(s7_y_reg[43:15]);
    assign s8_qq_next = s8_q * s8_q;

    always_ff @(posedge clk)
    begin
        s8_qq_reg <= s8_qq_next;
        s8_y_reg  <= s7_y_reg;
    end

    // Stage 9: final quadratic correction
    logic signed [50:0] s9_qs;
    logic signed [59:0] s9_r_next, s9_r_reg;
    logic signed [47:0] s9_y_reg;

    assign s9_qs     = $signed(s8_qq_reg[57:7]);
    assign s9_r_next = s9_qs * $signed({1'b0, h1_reg});

    always_ff @(posedge clk)
    begin
        s9_r_reg <= s9_r_next;
        s9_y_reg <= s8_y_reg;
    end

    // Stage 10: subtract, saturate and drive the result word
    logic signed [56:0] s10_yf;
    logic        [16:0] s10_hum_next;

    assign s10_yf = {{9{s9_y_reg[47]}}, s9_y_reg} - $signed(s9_r_reg[59:4]);

    always_comb
    begin
        if (s10_yf < 57'sd0)
            s10_hum_next = '0;
        else if (s10_yf > HUM_Q_MAX)
            s10_hum_next = HUM_Q_MAX[28:12];
        else
            s10_hum_next = s10_yf[28:12];
    end

    always_ff @(posedge clk)
    begin
        humidity_frac <= s10_hum_next;
    end

    assign temperature_centi = temp_pipe_reg[STAGES];
    assign fine_temperature  = fine_pipe_reg[STAGES];

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for humidity_temperature_compensation
// Drives raw temperature and humidity words through the command port. Each
// word's compensated temperature, humidity and fine temperature are worked
// out by an integer predictor and checked against every done pulse. Several
// calibration settings are exercised, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import htc_pkg::*;

    localparam int PIPE_DEPTH  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1200;
    localparam int N_DIRECTED  = 14;

    typedef struct packed {
        logic [14:0] temp;
        logic [16:0] hum;
        logic [19:0] fine;
    } reading_t;

    // Directed row: inputs, plus an optional typed-in expectation.
    typedef struct {
        logic [19:0] raw_t;
        logic [15:0] raw_h;
        bit          typed;
        reading_t    exp_val;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 wr_en = 1'b0;
    logic [2:0]           wr_index = '0;
    logic [CFG_WIDTH-1:0] wr_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [19:0]          raw_temperature = '0;
    logic [15:0]          raw_humidity = '0;
    logic                 done;
    logic signed [14:0]   temperature_centi;
    logic [16:0]          humidity_frac;
    logic signed [19:0]   fine_temperature;

    // Local copy of the calibration registers
    logic [CFG_WIDTH-1:0] calib [8];

    reading_t expected_readings [$];
    int       failures = 0;
    int       cycles = 0;
    bit       idle_free = 1'b0;
    row_t     rows [N_DIRECTED];

    humidity_temperature_compensation u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .start             (start),
        .busy              (busy),
        .raw_temperature   (raw_temperature),
        .raw_humidity      (raw_humidity),
        .done              (done),
        .temperature_centi (temperature_centi),
        .humidity_frac     (humidity_frac),
        .fine_temperature  (fine_temperature)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor division by a power of two: >>> on longint is arithmetic.
    function automatic longint fdiv(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Work out the compensated reading from the current calibration.
    function automatic reading_t compensate(logic [19:0] rt_in, logic [15:0] rh_in);
        longint t1, t2, t3, h1, h2, h3, h4, h5, h6, rt, rh;
        longint a, b, d, fine, tmp, x, u, v, y, q;
        reading_t r;
        t1 = longint'(calib[REG_TEMP_ONE][15:0]);
        t2 = longint'($signed(calib[REG_TEMP_TWO][15:0]));
        t3 = longint'($signed(calib[REG_TEMP_THREE][15:0]));
        h1 = longint'(calib[REG_HUM_ONE][7:0]);
        h2 = longint'($signed(calib[REG_HUM_TWO][15:0]));
        h3 = longint'(calib[REG_HUM_THREE][7:0]);
        h4 = longint'($signed(calib[REG_HUM_FOUR_FIVE][23:12]));
        h5 = longint'($signed(calib[REG_HUM_FOUR_FIVE][11:0]));
        h6 = longint'($signed(calib[REG_HUM_SIX][7:0]));
        rt = longint'(rt_in);
        rh = longint'(rh_in);
        a = fdiv(((rt >>> 3) - 2 * t1) * t2, 11);
        d = (rt >>> 4) - t1;
        b = fdiv(fdiv(d * d, 12) * t3, 14);
        fine = clip(a + b, -524288, 524287);
        tmp = clip(fdiv(fine * 5 + 128, 8), -4000, 8500);
        x = fine - 76800;
        u = fdiv(rh * 16384 - h4 * 1048576 - h5 * x + 16384, 15);
        v = fdiv(fdiv(x * h6, 10) * (fdiv(x * h3, 11) + 32768), 10);
        v = fdiv((v + 2097152) * h2 + 8192, 14);
        y = u * v;
        q = fdiv(y, 15);
        y = y - fdiv(fdiv(q * q, 7) * h1, 4);
        y = clip(y, 0, 419430400);
        r.temp = tmp[14:0];
        r.hum  = y[28:12];
        r.fine = fine[19:0];
        return r;
    endfunction

    task automatic write_calib(reg_index_t idx, logic [CFG_WIDTH-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        calib[idx] = val;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Drop start, drain all expected readings, then let the pipe empty fully.
    task automatic settle();
        start <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Present one word at the current edge; hold start until it is taken.
    // A random idle gap comes first in one call out of four, unless idling is off.
    task automatic send_word(logic [19:0] rt, logic [15:0] rh, bit typed, reading_t ev);
        if (!idle_free && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start           <= 1'b1;
        raw_temperature <= rt;
        raw_humidity    <= rh;
        do
            @(posedge clk);
        while (busy);
        expected_readings.push_back(typed ? ev : compensate(rt, rh));
    endtask

    // Random calibration set; extremes appear now and then.
    task automatic random_calib();
        for (int i = 0; i < 8; i++)
        begin
            logic [CFG_WIDTH-1:0] val;
            case ($urandom_range(0, 5))
                0: val = '0;
                1: val = '1;
                default: val = CFG_WIDTH'($urandom);
            endcase
            write_calib(reg_index_t'(i), val);
        end
    endtask

    // Raw temperature biased towards a realistic window around t1.
    function automatic logic [19:0] pick_raw_t();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return 20'($urandom);
        return 20'((int'(calib[REG_TEMP_ONE][15:0]) << 4) + $urandom_range(0, 8191) - 4096);
    endfunction

    // Check each done pulse against the oldest expectation.
    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected reading: temperature_centi %0d", temperature_centi);
                failures++;
            end
            else
            begin
                e = expected_readings.pop_front();
                if (temperature_centi !== e.temp)
                begin
                    $error("temperature_centi: expected %0d, got %0d",
                           $signed(e.temp), temperature_centi);
                    failures++;
                end
                if (humidity_frac !== e.hum)
                begin
                    $error("humidity_frac: expected %0d, got %0d", e.hum, humidity_frac);
                    failures++;
                end
                if (fine_temperature !== e.fine)
                begin
                    $error("fine_temperature: expected %0d, got %0d",
                           $signed(e.fine), fine_temperature);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** humidity_temperature_compensation: FAILED **");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            calib[i] = '0;

        // With all-zero calibration: fine and temperature are zero, humidity
        // is zero since the gain is zero.
        rows[0] = '{20'h00000, 16'h0000, 1'b1, '{15'd0, 17'd0, 20'd0}};
        rows[1] = '{20'hFFFFF, 16'hFFFF, 1'b1, '{15'd0, 17'd0, 20'd0}};
        rows[2] = '{20'h80000, 16'h8000, 1'b1, '{15'd0, 17'd0, 20'd0}};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 3; i++)
            send_word(rows[i].raw_t, rows[i].raw_h, rows[i].typed, rows[i].exp_val);
        settle();

        // Typical published calibration, then extremes; predictor-checked rows.
        write_calib(REG_TEMP_ONE, 24'd27504);
        write_calib(REG_TEMP_TWO, 24'd26435);
        write_calib(REG_TEMP_THREE, 24'(-16'sd1000));
        write_calib(REG_HUM_ONE, 24'd75);
        write_calib(REG_HUM_TWO, 24'd362);
        write_calib(REG_HUM_THREE, 24'd0);
        write_calib(REG_HUM_FOUR_FIVE, {12'd313, 12'd50});
        write_calib(REG_HUM_SIX, 24'd30);
        rows[3]  = '{20'd519888, 16'd30000, 1'b0, '0};
        rows[4]  = '{20'd0, 16'd0, 1'b0, '0};
        rows[5]  = '{20'hFFFFF, 16'hFFFF, 1'b0, '0};
        rows[6]  = '{20'd440064, 16'd65535, 1'b0, '0};
        rows[7]  = '{20'd600000, 16'd1, 1'b0, '0};
        rows[8]  = '{20'd300000, 16'd20000, 1'b0, '0};
        rows[9]  = '{20'd700000, 16'd45000, 1'b0, '0};
        rows[10] = '{20'h55555, 16'h5555, 1'b0, '0};
        rows[11] = '{20'hAAAAA, 16'hAAAA, 1'b0, '0};
        rows[12] = '{20'd520000, 16'd0, 1'b0, '0};
        rows[13] = '{20'd520000, 16'd50000, 1'b0, '0};
        for (int i = 3; i < N_DIRECTED; i++)
            send_word(rows[i].raw_t, rows[i].raw_h, 1'b0, rows[i].exp_val);
        settle();

        // All-ones registers: drives humidity into saturation.
        for (int i = 0; i < 8; i++)
            write_calib(reg_index_t'(i), '1);
        send_word(20'hFFFFF, 16'hFFFF, 1'b0, '0);
        send_word(20'h00000, 16'h0000, 1'b0, '0);
        send_word(20'h7FFFF, 16'h0001, 1'b0, '0);
        settle();

        // Random part in phases, each with a fresh calibration set; the last
        // phase runs with no idling.
        for (int ph = 0; ph < 8; ph++)
        begin
            random_calib();
            if (ph == 7)
                idle_free = 1'b1;
            for (int n = 0; n < RANDOM_WORDS / 8; n++)
                send_word(pick_raw_t(), 16'($urandom), 1'b0, '0);
            settle();
        end

        if (failures == 0)
            $display("** humidity_temperature_compensation: PASSED **");
        else
            $display("** humidity_temperature_compensation: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
